/* rtl/core/tws_pkg.sv */
// timing wheel scheduler package: widths, codes, entry layout, arming math
// no dependencies; used by every module of the block but tws_ram
package tws_pkg;

  localparam int MAX_EVENTS_DEF = 64;
  localparam int WHEEL_SLOTS    = 256;
  localparam int SLOT_W         = 8;
  localparam int ROUND_W        = 16;
  localparam int GEN_BITS       = 8;
  localparam int POS_BITS       = 6;
  localparam int HANDLE_W       = GEN_BITS + POS_BITS;
  localparam int TICK_W         = 32;
  localparam int REP_W          = 16;
  localparam logic [REP_W-1:0] REP_FOREVER = '1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DELAY  = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_NOTFOUND = 2'd2
  } sts_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [ROUND_W-1:0] round;
  } when_t;

  typedef struct packed {
    logic [GEN_BITS-1:0] gen;
    logic [TICK_W-1:0]   period;
    logic [REP_W-1:0]    repeats;
    when_t               due;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_SRCH, ST_CLAIM, ST_POST, ST_LOOK,
    ST_TK_RD, ST_TK_EV, ST_TK_END
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_FULL, OP_NOTFOUND, OP_SRCH_START, OP_STEP,
    OP_CLAIM, OP_REMOVE, OP_DELAY, OP_TK_START, OP_TK_FIRE, OP_TK_SKIP,
    OP_TK_END
  } op_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic lk_bad;
    logic gen_ok;
    logic can_emit;
    logic alloc_busy;
    logic tk_match;
    logic scan_last;
    logic pend;
  } dp_sts_t;

  // slot and round at which an event lands, ticks after base
  function automatic when_t arm(input logic [TICK_W-1:0] ticks,
                                input logic [SLOT_W:0] base,
                                input logic [ROUND_W-1:0] cur_round);
    logic [TICK_W:0] idx;
    when_t w;
    idx = {1'b0, ticks} + (TICK_W+1)'(base);
    w.slot = idx[SLOT_W-1:0];
    w.round = cur_round + idx[SLOT_W+ROUND_W-1:SLOT_W];
    return w;
  endfunction

endpackage

/* rtl/core/tws_ram.sv */
// generic single write port ram with registered read
// no dependencies
module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tws_ctrl.sv */
// timing wheel controller: sequences insert search, lookup and tick scan
// depends on tws_pkg
module tws_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tws_pkg::dp_sts_t sts,
  output tws_pkg::op_t     op
);

  tws_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tws_pkg::ST_IDLE: if (in_valid) state_nxt = tws_pkg::ST_DISP;
      tws_pkg::ST_DISP: begin
        case (sts.cmd)
          tws_pkg::CMD_INSERT: begin
            if (!sts.full) state_nxt = tws_pkg::ST_SRCH;
            else if (sts.can_emit) state_nxt = tws_pkg::ST_IDLE;
          end
          tws_pkg::CMD_REMOVE, tws_pkg::CMD_DELAY: begin
            if (!sts.lk_bad) state_nxt = tws_pkg::ST_LOOK;
            else if (sts.can_emit) state_nxt = tws_pkg::ST_IDLE;
          end
          default: state_nxt = tws_pkg::ST_TK_RD;
        endcase
      end
      tws_pkg::ST_SRCH: if (!sts.alloc_busy) state_nxt = tws_pkg::ST_CLAIM;
      tws_pkg::ST_CLAIM: if (sts.can_emit) state_nxt = tws_pkg::ST_POST;
      tws_pkg::ST_POST: if (!sts.alloc_busy) state_nxt = tws_pkg::ST_IDLE;
      tws_pkg::ST_LOOK: if (sts.can_emit) state_nxt = tws_pkg::ST_IDLE;
      tws_pkg::ST_TK_RD: state_nxt = tws_pkg::ST_TK_EV;
      tws_pkg::ST_TK_EV: begin
        if (!(sts.tk_match && sts.pend && !sts.can_emit)) begin
          state_nxt = sts.scan_last ? tws_pkg::ST_TK_END : tws_pkg::ST_TK_RD;
        end
      end
      tws_pkg::ST_TK_END: if (sts.can_emit) state_nxt = tws_pkg::ST_IDLE;
      default: state_nxt = tws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op = tws_pkg::OP_NONE;
    in_stall = 1'b1;
    case (state_r)
      tws_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) op = tws_pkg::OP_CAPTURE;
      end
      tws_pkg::ST_DISP: begin
        case (sts.cmd)
          tws_pkg::CMD_INSERT: begin
            if (!sts.full) op = tws_pkg::OP_SRCH_START;
            else if (sts.can_emit) op = tws_pkg::OP_FULL;
          end
          tws_pkg::CMD_REMOVE, tws_pkg::CMD_DELAY: begin
            if (sts.lk_bad && sts.can_emit) op = tws_pkg::OP_NOTFOUND;
          end
          default: op = tws_pkg::OP_TK_START;
        endcase
      end
      tws_pkg::ST_SRCH, tws_pkg::ST_POST: if (sts.alloc_busy) op = tws_pkg::OP_STEP;
      tws_pkg::ST_CLAIM: if (sts.can_emit) op = tws_pkg::OP_CLAIM;
      tws_pkg::ST_LOOK: begin
        if (sts.can_emit) begin
          if (!sts.gen_ok) op = tws_pkg::OP_NOTFOUND;
          else if (sts.cmd == tws_pkg::CMD_REMOVE) op = tws_pkg::OP_REMOVE;
          else op = tws_pkg::OP_DELAY;
        end
      end
      tws_pkg::ST_TK_EV: begin
        if (!sts.tk_match) op = tws_pkg::OP_TK_SKIP;
        else if (!sts.pend || sts.can_emit) op = tws_pkg::OP_TK_FIRE;
      end
      tws_pkg::ST_TK_END: if (sts.can_emit) op = tws_pkg::OP_TK_END;
      default: op = tws_pkg::OP_NONE;
    endcase
  end

endmodule

/* rtl/core/tws_dp.sv */
// timing wheel datapath: entry table, valid bits, allocator, wheel position
// depends on tws_pkg and tws_ram
module tws_dp #(
  parameter int MAX_EVENTS = tws_pkg::MAX_EVENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tws_pkg::op_t                    op,
  output tws_pkg::dp_sts_t                sts,
  input  logic [1:0]                      in_command,
  input  logic [tws_pkg::HANDLE_W-1:0]    in_target_handle,
  input  logic [tws_pkg::TICK_W-1:0]      in_delay_ticks,
  input  logic [tws_pkg::TICK_W-1:0]      in_period_ticks,
  input  logic [tws_pkg::REP_W-1:0]       in_repeat_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tws_pkg::HANDLE_W-1:0]    out_result_handle,
  output logic [1:0]                      out_status,
  output logic [tws_pkg::TICK_W-1:0]      out_remaining_ticks,
  output logic                            out_fired,
  output logic [tws_pkg::REP_W-1:0]       out_repeats_left,
  output logic                            out_last
);

  localparam int IDX_W = $clog2(MAX_EVENTS);
  localparam int CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int PB = tws_pkg::POS_BITS;
  localparam int GB = tws_pkg::GEN_BITS;
  localparam int SW = tws_pkg::SLOT_W;
  localparam int RW = tws_pkg::ROUND_W;
  localparam int TW = tws_pkg::TICK_W;
  localparam int HW = tws_pkg::HANDLE_W;
  localparam int EW = $bits(tws_pkg::entry_t);

  tws_pkg::cmd_t     cmd_r;
  logic [HW-1:0]     th_r;
  logic [TW-1:0]     dly_r, per_r;
  logic [tws_pkg::REP_W-1:0] rep_r;
  logic [MAX_EVENTS-1:0] valid_r;
  logic [SW-1:0]     cur_slot_r;
  logic [RW-1:0]     cur_round_r;
  logic [IDX_W-1:0]  apos_r, scan_r;
  logic [GB-1:0]     agen_r;
  logic [CNT_W-1:0]  live_r, cnt_r;
  logic              pend_r;
  logic [HW-1:0]     pend_h_r;
  logic [tws_pkg::REP_W-1:0] pend_rep_r;
  logic              out_valid_r, out_fired_r, out_last_r;
  logic [HW-1:0]     out_h_r;
  logic [1:0]        out_sts_r;
  logic [TW-1:0]     out_rem_r;
  logic [tws_pkg::REP_W-1:0] out_rep_r;

  logic [PB-1:0]     th_pos;
  logic [IDX_W-1:0]  th_idx, raddr, waddr, apos_step;
  logic              apos_wrap, we;
  tws_pkg::entry_t   rd, wdata;
  logic [EW-1:0]     rdata_raw;
  logic [tws_pkg::REP_W-1:0] fire_rep;
  logic [TW-1:0]     rem;

  assign th_pos = th_r[PB-1:0];
  assign th_idx = th_pos[IDX_W-1:0];
  assign raddr = (cmd_r == tws_pkg::CMD_TICK) ? scan_r : th_idx;
  assign rd = tws_pkg::entry_t'(rdata_raw);

  assign apos_wrap = (apos_r == IDX_W'(MAX_EVENTS - 1));
  assign apos_step = apos_wrap ? '0 : apos_r + 1'b1;

  // repeat count after a firing: forever and zero both hold
  assign fire_rep = (rd.repeats != tws_pkg::REP_FOREVER && rd.repeats != '0) ?
                    rd.repeats - 1'b1 : rd.repeats;

  assign rem = (TW'(rd.due.slot) - TW'(cur_slot_r)) +
               {{(TW-RW-SW){1'b0}}, RW'(rd.due.round - cur_round_r), {SW{1'b0}}};

  always_comb begin
    we = 1'b0;
    waddr = apos_r;
    wdata = rd;
    case (op)
      tws_pkg::OP_CLAIM: begin
        we = 1'b1;
        wdata.gen = agen_r;
        wdata.period = per_r;
        wdata.repeats = rep_r;
        wdata.due = tws_pkg::arm(dly_r, {1'b0, cur_slot_r}, cur_round_r);
      end
      tws_pkg::OP_DELAY: begin
        we = 1'b1;
        waddr = th_idx;
        wdata.due = tws_pkg::arm(rd.period + dly_r, {1'b0, cur_slot_r}, cur_round_r);
      end
      tws_pkg::OP_TK_FIRE: begin
        we = 1'b1;
        waddr = scan_r;
        wdata.repeats = fire_rep;
        wdata.due = tws_pkg::arm(rd.period, {1'b0, cur_slot_r} + 1'b1, cur_round_r);
      end
      default: we = 1'b0;
    endcase
  end

  tws_ram #(.WIDTH(EW), .DEPTH(MAX_EVENTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  always_comb begin
    sts.cmd = cmd_r;
    sts.full = (live_r == CNT_W'(MAX_EVENTS));
    sts.lk_bad = ({1'b0, th_pos} >= (PB+1)'(MAX_EVENTS)) || !valid_r[th_idx];
    sts.gen_ok = (rd.gen == th_r[HW-1:PB]);
    sts.can_emit = !out_valid_r;
    sts.alloc_busy = valid_r[apos_r] && (cnt_r < CNT_W'(MAX_EVENTS));
    sts.tk_match = valid_r[scan_r] && (rd.due.slot == cur_slot_r) &&
                   (rd.due.round == cur_round_r);
    sts.scan_last = (scan_r == IDX_W'(MAX_EVENTS - 1));
    sts.pend = pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cur_slot_r  <= '0;
      cur_round_r <= '0;
      apos_r      <= '0;
      agen_r      <= GB'(1);
      live_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (op)
        tws_pkg::OP_CAPTURE: begin
          cmd_r <= tws_pkg::cmd_t'(in_command);
          th_r  <= in_target_handle;
          dly_r <= in_delay_ticks;
          per_r <= in_period_ticks;
          rep_r <= in_repeat_count;
        end
        tws_pkg::OP_FULL, tws_pkg::OP_NOTFOUND: begin
          out_valid_r <= 1'b1;
          out_h_r     <= (op == tws_pkg::OP_FULL) ? '0 : th_r;
          out_sts_r   <= (op == tws_pkg::OP_FULL) ? tws_pkg::STS_FULL :
                                                    tws_pkg::STS_NOTFOUND;
          out_rem_r   <= '0;
          out_fired_r <= 1'b0;
          out_rep_r   <= '0;
          out_last_r  <= 1'b1;
        end
        tws_pkg::OP_SRCH_START: cnt_r <= '0;
        tws_pkg::OP_STEP: begin
          apos_r <= apos_step;
          if (apos_wrap) agen_r <= agen_r + 1'b1;
          cnt_r <= cnt_r + 1'b1;
        end
        tws_pkg::OP_CLAIM: begin
          valid_r[apos_r] <= 1'b1;
          live_r <= live_r + 1'b1;
          apos_r <= apos_step;
          if (apos_wrap) agen_r <= agen_r + 1'b1;
          cnt_r <= CNT_W'(1);
          out_valid_r <= 1'b1;
          out_h_r     <= {agen_r, PB'(apos_r)};
          out_sts_r   <= tws_pkg::STS_OK;
          out_rem_r   <= '0;
          out_fired_r <= 1'b0;
          out_rep_r   <= '0;
          out_last_r  <= 1'b1;
        end
        tws_pkg::OP_REMOVE, tws_pkg::OP_DELAY: begin
          if (op == tws_pkg::OP_REMOVE) begin
            valid_r[th_idx] <= 1'b0;
            live_r <= live_r - 1'b1;
          end
          out_valid_r <= 1'b1;
          out_h_r     <= th_r;
          out_sts_r   <= tws_pkg::STS_OK;
          out_rem_r   <= (op == tws_pkg::OP_REMOVE) ? rem : '0;
          out_fired_r <= 1'b0;
          out_rep_r   <= '0;
          out_last_r  <= 1'b1;
        end
        tws_pkg::OP_TK_START: begin
          scan_r <= '0;
          pend_r <= 1'b0;
        end
        tws_pkg::OP_TK_FIRE, tws_pkg::OP_TK_SKIP: begin
          scan_r <= scan_r + 1'b1;
          if (op == tws_pkg::OP_TK_FIRE) begin
            // the held firing goes out only once a later one proves it is not last
            if (pend_r) begin
              out_valid_r <= 1'b1;
              out_h_r     <= pend_h_r;
              out_sts_r   <= tws_pkg::STS_OK;
              out_rem_r   <= '0;
              out_fired_r <= 1'b1;
              out_rep_r   <= pend_rep_r;
              out_last_r  <= 1'b0;
            end
            pend_r     <= 1'b1;
            pend_h_r   <= {rd.gen, PB'(scan_r)};
            pend_rep_r <= fire_rep;
            if (fire_rep == '0) begin
              valid_r[scan_r] <= 1'b0;
              live_r <= live_r - 1'b1;
            end
          end
        end
        tws_pkg::OP_TK_END: begin
          out_valid_r <= 1'b1;
          out_h_r     <= pend_r ? pend_h_r : '0;
          out_sts_r   <= tws_pkg::STS_OK;
          out_rem_r   <= '0;
          out_fired_r <= pend_r;
          out_rep_r   <= pend_r ? pend_rep_r : '0;
          out_last_r  <= 1'b1;
          pend_r      <= 1'b0;
          cur_slot_r  <= cur_slot_r + 1'b1;
          if (cur_slot_r == SW'(tws_pkg::WHEEL_SLOTS - 1)) cur_round_r <= cur_round_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_handle   = out_h_r;
  assign out_status          = out_sts_r;
  assign out_remaining_ticks = out_rem_r;
  assign out_fired           = out_fired_r;
  assign out_repeats_left    = out_rep_r;
  assign out_last            = out_last_r;

endmodule

/* rtl/core/timing_wheel_scheduler.sv */
// Hashed timing wheel with handle allocation, one item at a time. Insert steps
// the allocator over occupied positions to a free one, claims it, then steps
// on past occupied positions; an insert into a full table is answered full
// from dispatch; remove and delay read the handle's entry from the ram, or
// answer not found from dispatch when the handle's position is free; a tick
// reads every table position in turn through the entry ram, rewriting those
// that fire, and waits whenever the result channel stalls. Results leave
// through an output register, so one result beat may wait downstream while
// the block finishes the item. A tick always returns at least one beat;
// out_last marks the final beat of an item.
// depends on tws_pkg, tws_ctrl, tws_dp, tws_ram
module timing_wheel_scheduler #(
  parameter int MAX_EVENTS = tws_pkg::MAX_EVENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic [tws_pkg::HANDLE_W-1:0] in_target_handle,
  input  logic [tws_pkg::TICK_W-1:0]   in_delay_ticks,
  input  logic [tws_pkg::TICK_W-1:0]   in_period_ticks,
  input  logic [tws_pkg::REP_W-1:0]    in_repeat_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tws_pkg::HANDLE_W-1:0] out_result_handle,
  output logic [1:0]                   out_status,
  output logic [tws_pkg::TICK_W-1:0]   out_remaining_ticks,
  output logic                         out_fired,
  output logic [tws_pkg::REP_W-1:0]    out_repeats_left,
  output logic                         out_last
);

  tws_pkg::op_t     op;
  tws_pkg::dp_sts_t sts;

  tws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .op       (op)
  );

  tws_dp #(.MAX_EVENTS(MAX_EVENTS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .sts                 (sts),
    .in_command          (in_command),
    .in_target_handle    (in_target_handle),
    .in_delay_ticks      (in_delay_ticks),
    .in_period_ticks     (in_period_ticks),
    .in_repeat_count     (in_repeat_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_handle   (out_result_handle),
    .out_status          (out_status),
    .out_remaining_ticks (out_remaining_ticks),
    .out_fired           (out_fired),
    .out_repeats_left    (out_repeats_left),
    .out_last            (out_last)
  );

endmodule
